// ===== rtl/vpr_pkg.sv =====
// shared types and constants for the virtual packet reassembler
// no dependencies; used by every rtl module and by the dv files
package vpr_pkg;

  localparam int unsigned HEADER_BYTES     = 6;
  localparam int unsigned LEN_BYTES        = 4;
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam int unsigned HIDX_W           = 3;

  // raw packet classes
  localparam logic [1:0] CLS_DATA = 2'd0;
  localparam logic [1:0] CLS_LAST = 2'd1;

  // receive model codes
  localparam logic [1:0] RM_MULT64 = 2'd0;
  localparam logic [1:0] RM_PLUS5  = 2'd1;

  localparam logic [5:0] MOD64_PLUS5_HIT = 6'd59;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TYPE = 2'd1,
    ST_SHORT    = 2'd2,
    ST_MISMATCH = 2'd3
  } status_e;

  // classified word handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       present;
    logic       raw_end;
    logic       bad_class;
    logic       is_last;
    logic       short_len;
    logic       extra;
  } entry_t;

endpackage

// ===== rtl/vpr_in_if.sv =====
// input channel: one raw-packet byte word with valid/ready
// depends on nothing
interface vpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] packet_class;
  logic [9:0] raw_length;
  logic       raw_end;
  logic       byte_present;

  modport source (output valid, data_byte, packet_class, raw_length, raw_end, byte_present,
                  input ready);
  modport sink   (input valid, data_byte, packet_class, raw_length, raw_end, byte_present,
                  output ready);
endinterface

// ===== rtl/vpr_out_if.sv =====
// output channel: one result word with valid/ready
// depends on nothing
interface vpr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic [15:0] message_type;
  logic [31:0] declared_length;
  logic [31:0] received_length;
  logic        send_ack;
  logic        extra_empty_read;
  logic        message_end;
  logic [1:0]  status;

  modport source (output valid, payload_byte, payload_valid, message_type, declared_length,
                  received_length, send_ack, extra_empty_read, message_end, status,
                  input ready);
  modport sink   (input valid, payload_byte, payload_valid, message_type, declared_length,
                  received_length, send_ack, extra_empty_read, message_end, status,
                  output ready);
endinterface

// ===== rtl/vpr_front.sv =====
// front end: accepts input words, holds the receive model register and
// classifies each word for the back end; depends on vpr_pkg and vpr_in_if
module vpr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  vpr_in_if.sink          in_i,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_data_i,
  input  logic            full_i,
  output logic            push_o,
  output vpr_pkg::entry_t push_data_o
);

  logic [1:0] rm_q;
  logic       extra;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rm_q <= vpr_pkg::RM_MULT64;
    end else if (cfg_we_i) begin
      rm_q <= cfg_data_i;
    end
  end

  // modulo-64 rule uses the low six bits only
  always_comb begin
    unique case (rm_q)
      vpr_pkg::RM_MULT64: extra = (in_i.raw_length[5:0] == 6'd0);
      vpr_pkg::RM_PLUS5:  extra = (in_i.raw_length[5:0] == vpr_pkg::MOD64_PLUS5_HIT);
      default:            extra = 1'b0;
    endcase
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    push_data_o.data_byte = in_i.data_byte;
    push_data_o.present   = in_i.byte_present;
    push_data_o.raw_end   = in_i.raw_end;
    push_data_o.bad_class = (in_i.packet_class != vpr_pkg::CLS_DATA) &&
                            (in_i.packet_class != vpr_pkg::CLS_LAST);
    push_data_o.is_last   = (in_i.packet_class == vpr_pkg::CLS_LAST);
    push_data_o.short_len = (in_i.raw_length < 10'(vpr_pkg::HEADER_BYTES));
    push_data_o.extra     = extra;
  end

endmodule

// ===== rtl/vpr_queue.sv =====
// short queue of classified words between front and back
// depends on vpr_pkg
module vpr_queue #(
  parameter int unsigned DEPTH = vpr_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vpr_pkg::entry_t push_data_i,
  input  logic            pop_i,
  output vpr_pkg::entry_t pop_data_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  vpr_pkg::entry_t mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/vpr_back.sv =====
// back end: message state (header capture, payload count) and the output
// register; depends on vpr_pkg and vpr_out_if
module vpr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  vpr_pkg::entry_t pop_data_i,
  output logic            pop_o,
  vpr_out_if.source       out_o
);

  logic                       first_q, first_d;
  logic [vpr_pkg::HIDX_W-1:0] hidx_q, hidx_d;
  logic [31:0]                len_q, len_d;
  logic [15:0]                type_q, type_d;
  logic [31:0]                cnt_q, cnt_d;

  logic                       ovalid_q;
  logic [7:0]                 pbyte_q, pbyte_d;
  logic                       pvalid_q, pvalid_d;
  logic [15:0]                otype_q;
  logic [31:0]                olen_q, ocnt_q;
  logic                       ack_q, ack_d;
  logic                       extra_q, extra_d;
  logic                       mend_q, mend_d;
  vpr_pkg::status_e           status_q, status_d;
  logic                       finish;

  assign pop_o = !empty_i && (!ovalid_q || out_o.ready);

  always_comb begin
    first_d  = first_q;
    hidx_d   = hidx_q;
    len_d    = len_q;
    type_d   = type_q;
    cnt_d    = cnt_q;
    pbyte_d  = 8'd0;
    pvalid_d = 1'b0;
    ack_d    = 1'b0;
    extra_d  = 1'b0;
    mend_d   = 1'b0;
    status_d = vpr_pkg::ST_OK;
    finish   = 1'b0;
    if (pop_data_i.bad_class) begin
      status_d = vpr_pkg::ST_BAD_TYPE;
      mend_d   = 1'b1;
      finish   = 1'b1;
    end else if (first_q && pop_data_i.short_len) begin
      status_d = vpr_pkg::ST_SHORT;
      mend_d   = 1'b1;
      finish   = 1'b1;
    end else begin
      if (pop_data_i.present) begin
        if (first_q && (hidx_q < vpr_pkg::HIDX_W'(vpr_pkg::HEADER_BYTES))) begin
          if (hidx_q < vpr_pkg::HIDX_W'(vpr_pkg::LEN_BYTES)) begin
            len_d = {len_q[23:0], pop_data_i.data_byte};
          end else begin
            type_d = {type_q[7:0], pop_data_i.data_byte};
          end
          hidx_d = hidx_q + 1'b1;
        end else begin
          pvalid_d = 1'b1;
          pbyte_d  = pop_data_i.data_byte;
          if (cnt_q != '1) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      if (pop_data_i.raw_end) begin
        // header must be complete by the end of the first packet
        if (first_q && (hidx_d < vpr_pkg::HIDX_W'(vpr_pkg::HEADER_BYTES))) begin
          status_d = vpr_pkg::ST_SHORT;
          mend_d   = 1'b1;
          finish   = 1'b1;
        end else begin
          ack_d   = 1'b1;
          extra_d = pop_data_i.extra;
          first_d = 1'b0;
          if (pop_data_i.is_last) begin
            mend_d = 1'b1;
            finish = 1'b1;
            if (len_d != cnt_d) begin
              status_d = vpr_pkg::ST_MISMATCH;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= 1'b1;
      hidx_q   <= '0;
      len_q    <= '0;
      type_q   <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      if (pop_o) begin
        if (finish) begin
          first_q <= 1'b1;
          hidx_q  <= '0;
          len_q   <= '0;
          type_q  <= '0;
          cnt_q   <= '0;
        end else begin
          first_q <= first_d;
          hidx_q  <= hidx_d;
          len_q   <= len_d;
          type_q  <= type_d;
          cnt_q   <= cnt_d;
        end
      end
    end
  end

  // result shows the values before any clear
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pbyte_q  <= pbyte_d;
      pvalid_q <= pvalid_d;
      otype_q  <= type_d;
      olen_q   <= len_d;
      ocnt_q   <= cnt_d;
      ack_q    <= ack_d;
      extra_q  <= extra_d;
      mend_q   <= mend_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid            = ovalid_q;
  assign out_o.payload_byte     = pbyte_q;
  assign out_o.payload_valid    = pvalid_q;
  assign out_o.message_type     = otype_q;
  assign out_o.declared_length  = olen_q;
  assign out_o.received_length  = ocnt_q;
  assign out_o.send_ack         = ack_q;
  assign out_o.extra_empty_read = extra_q;
  assign out_o.message_end      = mend_q;
  assign out_o.status           = status_q;

endmodule

// ===== rtl/virtual_packet_reassembler.sv =====
// virtual packet reassembler: rebuilds length-prefixed messages from bytes
// an accepted word is written into the queue, then registered in the back-end output register
// throughput: one word per cycle while the output is ready, set by the back-end state update
// the queue between front and back absorbs output stalls up to its depth
// reset (rst_ni low, asynchronous) clears message state, queue and receive model
module virtual_packet_reassembler #(
  parameter int unsigned QUEUE_DEPTH = vpr_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vpr_in_if.sink     in_i,
  vpr_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i
);

  logic            push, pop, full, empty;
  vpr_pkg::entry_t push_data, pop_data;

  vpr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  vpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  vpr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_o      (out_o)
  );

  a_extra_needs_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.extra_empty_read |-> out_o.send_ack)
    else $error("extra empty read without ack");

  a_mismatch_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == vpr_pkg::ST_MISMATCH) |->
      out_o.message_end && out_o.send_ack)
    else $error("length mismatch not at acknowledged message end");

  a_error_no_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && ((out_o.status == vpr_pkg::ST_BAD_TYPE) ||
                    (out_o.status == vpr_pkg::ST_SHORT)) |->
      out_o.message_end && !out_o.send_ack && !out_o.payload_valid)
    else $error("error word acknowledged or carrying payload");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("queue popped while empty");

endmodule

// ===== dv/vpr_checker.sv =====
// result checker for the virtual packet reassembler: predicts and compares every result word
// depends on vpr_pkg and the vpr_in_if / vpr_out_if interfaces from rtl
module vpr_checker
  import vpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  vpr_in_if           in_mon_i,
  vpr_out_if          out_mon_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_data_i,
  output int unsigned mismatch_count_o,
  output int unsigned words_pending_o
);

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [15:0] message_type;
    logic [31:0] declared_length;
    logic [31:0] received_length;
    logic        send_ack;
    logic        extra_empty_read;
    logic        message_end;
    status_e     status;
  } result_t;

  result_t     expected_q[$];
  result_t     want;
  logic [1:0]  rx_model = RM_MULT64;
  logic        first_pkt = 1'b1;
  logic [2:0]  hdr_idx = '0;
  logic [31:0] len_reg = '0;
  logic [15:0] type_reg = '0;
  logic [31:0] rcv_count = '0;
  int unsigned mismatches = 0;
  int unsigned pending_words = 0;

  assign mismatch_count_o = mismatches;
  assign words_pending_o  = pending_words;

  function automatic void clear_message();
    first_pkt = 1'b1;
    hdr_idx   = '0;
    len_reg   = '0;
    type_reg  = '0;
    rcv_count = '0;
  endfunction

  function automatic result_t predict_word(logic [7:0] b, logic [1:0] cls, logic [9:0] rlen,
                                           logic rend, logic pres);
    result_t     r;
    logic        done;
    logic [10:0] rlen_p5;
    r       = '0;
    r.status = ST_OK;
    done    = 1'b0;
    rlen_p5 = 11'(rlen) + 11'd5;
    if (cls != CLS_DATA && cls != CLS_LAST) begin
      r.status      = ST_BAD_TYPE;
      r.message_end = 1'b1;
      done          = 1'b1;
    end else if (first_pkt && rlen < HEADER_BYTES) begin
      r.status      = ST_SHORT;
      r.message_end = 1'b1;
      done          = 1'b1;
    end else begin
      if (pres) begin
        if (first_pkt && hdr_idx < HEADER_BYTES) begin
          // header is big-endian: length first, then type
          if (hdr_idx < LEN_BYTES) len_reg = {len_reg[23:0], b};
          else type_reg = {type_reg[7:0], b};
          hdr_idx++;
        end else begin
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
          if (rcv_count != '1) rcv_count++;
        end
      end
      if (rend) begin
        if (first_pkt && hdr_idx < HEADER_BYTES) begin
          r.status      = ST_SHORT;
          r.message_end = 1'b1;
          done          = 1'b1;
        end else begin
          r.send_ack = 1'b1;
          case (rx_model)
            RM_MULT64: r.extra_empty_read = (rlen[5:0] == 6'd0);
            RM_PLUS5:  r.extra_empty_read = (rlen_p5[5:0] == 6'd0);
            default:   r.extra_empty_read = 1'b0;
          endcase
          first_pkt = 1'b0;
          if (cls == CLS_LAST) begin
            r.message_end = 1'b1;
            done          = 1'b1;
            if (len_reg != rcv_count) r.status = ST_MISMATCH;
          end
        end
      end
    end
    // result shows the registers before any clear
    r.message_type    = type_reg;
    r.declared_length = len_reg;
    r.received_length = rcv_count;
    if (done) clear_message();
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, exp_val);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      rx_model = RM_MULT64;
      clear_message();
    end else begin
      if (cfg_we_i) rx_model = cfg_data_i;
      // compare before queuing, so a word can never match its own input
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", out_mon_i.received_length, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_mon_i.payload_byte != want.payload_byte)
            report_mismatch("payload_byte", out_mon_i.payload_byte, want.payload_byte);
          if (out_mon_i.payload_valid != want.payload_valid)
            report_mismatch("payload_valid", out_mon_i.payload_valid, want.payload_valid);
          if (out_mon_i.message_type != want.message_type)
            report_mismatch("message_type", out_mon_i.message_type, want.message_type);
          if (out_mon_i.declared_length != want.declared_length)
            report_mismatch("declared_length", out_mon_i.declared_length, want.declared_length);
          if (out_mon_i.received_length != want.received_length)
            report_mismatch("received_length", out_mon_i.received_length, want.received_length);
          if (out_mon_i.send_ack != want.send_ack)
            report_mismatch("send_ack", out_mon_i.send_ack, want.send_ack);
          if (out_mon_i.extra_empty_read != want.extra_empty_read)
            report_mismatch("extra_empty_read", out_mon_i.extra_empty_read,
                            want.extra_empty_read);
          if (out_mon_i.message_end != want.message_end)
            report_mismatch("message_end", out_mon_i.message_end, want.message_end);
          if (out_mon_i.status != want.status)
            report_mismatch("status", out_mon_i.status, want.status);
        end
      end
      if (in_mon_i.valid && in_mon_i.ready)
        expected_q.push_back(predict_word(in_mon_i.data_byte, in_mon_i.packet_class,
                                          in_mon_i.raw_length, in_mon_i.raw_end,
                                          in_mon_i.byte_present));
    end
    pending_words = expected_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
// top of the virtual packet reassembler bench: clock, reset, stimulus and verdict
// depends on vpr_pkg, the rtl interfaces, the rtl top and vpr_checker
module testbench;
  import vpr_pkg::*;

  localparam int unsigned ITEM_TARGET = 1050;
  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam logic [1:0]  CLS_OTHER    = 2'd2;
  localparam logic [1:0]  CLS_RESERVED = 2'd3;
  localparam int unsigned BIG_SIZES [5]  = '{58, 59, 64, 123, 128};
  localparam int unsigned SEND_IDLE [4]  = '{0, 80, 0, 9};
  localparam int unsigned RECV_STALL [4] = '{0, 0, 80, 9};

  typedef logic [7:0] byte_q_t[$];
  typedef int unsigned size_q_t[$];
  typedef enum int unsigned {
    FAULT_BAD_CLASS,
    FAULT_SHORT_LEN,
    FAULT_EARLY_END,
    FAULT_NOISE
  } fault_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_data = RM_MULT64;
  int unsigned mismatch_count;
  int unsigned words_pending;
  int unsigned sent_words = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          long_hold = 1'b0;
  bit          hold_done = 1'b0;

  vpr_in_if  in_ch ();
  vpr_out_if out_ch ();

  virtual_packet_reassembler DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  vpr_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_mon_i         (in_ch),
    .out_mon_i        (out_ch),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .words_pending_o  (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAIL virtual_packet_reassembler");
    $finish;
  end

  // receiver: random stalls, or one long hold-off counted here
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_word(logic [7:0] b, logic [1:0] cls, logic [9:0] rlen, logic rend,
                           logic pres);
    int unsigned gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 60) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.packet_class <= cls;
    in_ch.raw_length   <= rlen;
    in_ch.raw_end      <= rend;
    in_ch.byte_present <= pres;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_words++;
  endtask

  // an empty packet is a single word with no byte
  task automatic send_packet(byte_q_t bytes, logic [1:0] cls, logic [9:0] rlen);
    int unsigned n;
    n = bytes.size();
    if (n == 0) begin
      send_word(8'($urandom_range(255)), cls, rlen, 1'b1, 1'b0);
    end else begin
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 3)
          send_word(8'($urandom_range(255)), cls, rlen, 1'b0, 1'b0);
        send_word(bytes[i], cls, rlen, (i == n - 1), 1'b1);
      end
    end
  endtask

  task automatic send_message(logic [31:0] declared, logic [15:0] mtype, size_q_t sizes);
    byte_q_t     stream;
    byte_q_t     pkt;
    int unsigned total;
    total = 0;
    foreach (sizes[p]) total += sizes[p];
    for (int k = 3; k >= 0; k--) stream.push_back(declared[8*k +: 8]);
    stream.push_back(mtype[15:8]);
    stream.push_back(mtype[7:0]);
    while (stream.size() < total) stream.push_back(8'($urandom_range(255)));
    for (int p = 0; p < sizes.size(); p++) begin
      pkt.delete();
      for (int i = 0; i < sizes[p]; i++) pkt.push_back(stream.pop_front());
      send_packet(pkt, (p == sizes.size() - 1) ? CLS_LAST : CLS_DATA, 10'(sizes[p]));
    end
  endtask

  task automatic random_message();
    size_q_t     sizes;
    int unsigned n_pkts;
    int unsigned total;
    int unsigned pick;
    logic [31:0] declared;
    n_pkts = $urandom_range(1, 4);
    total  = 0;
    for (int p = 0; p < n_pkts; p++) begin
      pick = $urandom_range(99);
      // long packets reach the modulo-64 cases of the empty-read rule
      if (pick < 6) sizes.push_back(BIG_SIZES[$urandom_range(4)]);
      else if (pick < 16 && p != 0) sizes.push_back(0);
      else sizes.push_back($urandom_range(1, 9) + ((p == 0) ? HEADER_BYTES : 0));
      total += sizes[p];
    end
    pick = $urandom_range(99);
    if (pick < 80) declared = total - HEADER_BYTES;
    else if (pick < 90)
      declared = (total - HEADER_BYTES) + ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF);
    else declared = $urandom;
    send_message(declared, 16'($urandom_range(16'hFFFF)), sizes);
  endtask

  task automatic random_fault();
    fault_e      kind;
    int unsigned n;
    logic [9:0]  rlen;
    kind = fault_e'($urandom_range(3));
    case (kind)
      FAULT_BAD_CLASS: begin
        n    = $urandom_range(0, 8);
        rlen = 10'($urandom_range(6, 20));
        for (int i = 0; i < n; i++) send_word(8'($urandom_range(255)), CLS_DATA, rlen, 1'b0, 1'b1);
        send_word(8'($urandom_range(255)), CLS_OTHER + 2'($urandom_range(1)),
                  10'($urandom_range(1023)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      FAULT_SHORT_LEN: begin
        send_word(8'($urandom_range(255)), 2'($urandom_range(1)), 10'($urandom_range(5)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      FAULT_EARLY_END: begin
        n    = $urandom_range(1, 6);
        rlen = 10'($urandom_range(6, 1023));
        for (int i = 1; i < n; i++) send_word(8'($urandom_range(255)), CLS_DATA, rlen, 1'b0, 1'b1);
        send_word(8'($urandom_range(255)), 2'($urandom_range(1)), rlen, 1'b1,
                  (n < 6) ? 1'($urandom_range(1)) : 1'b0);
      end
      default: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          send_word(8'($urandom_range(255)), 2'($urandom_range(3)), 10'($urandom_range(1023)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    endcase
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (words_pending == 0);
    @(posedge clk);
  endtask

  initial begin
    size_q_t     sizes;
    int unsigned phase_end;
    in_ch.valid        <= 1'b0;
    in_ch.data_byte    <= '0;
    in_ch.packet_class <= CLS_DATA;
    in_ch.raw_length   <= '0;
    in_ch.raw_end      <= 1'b0;
    in_ch.byte_present <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray words of a wrong class before any message
    send_word(8'h00, CLS_OTHER, 10'd1023, 1'b1, 1'b1);
    send_word(8'hFF, CLS_RESERVED, 10'd0, 1'b0, 1'b0);
    // first packet too short for a header
    send_word(8'hA5, CLS_DATA, 10'd5, 1'b1, 1'b1);
    // first packet that ends inside the header
    send_word(8'h01, CLS_DATA, 10'd6, 1'b0, 1'b1);
    send_word(8'h02, CLS_DATA, 10'd6, 1'b0, 1'b1);
    send_word(8'h03, CLS_LAST, 10'd6, 1'b1, 1'b1);
    // header alone, an empty packet, then one payload byte
    sizes = '{HEADER_BYTES, 0, 1};
    send_message(32'd1, 16'hFFFF, sizes);
    // maximum declared length against one byte
    sizes = '{HEADER_BYTES + 1};
    send_message(32'hFFFF_FFFF, 16'h0000, sizes);
    // wrong class in the middle of a header
    send_word(8'h00, CLS_DATA, 10'd12, 1'b0, 1'b1);
    send_word(8'hFF, CLS_DATA, 10'd12, 1'b0, 1'b1);
    send_word(8'h5A, CLS_OTHER, 10'd12, 1'b0, 1'b1);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_for_results();
      cfg_we   <= 1'b1;
      cfg_data <= 2'(ph % 4);
      @(posedge clk);
      cfg_we         <= 1'b0;
      send_idle_pct  = SEND_IDLE[ph / 2];
      recv_stall_pct = RECV_STALL[ph / 2];
      // block fills up and back-pressures the sender
      if (ph == 0) long_hold = 1'b1;
      phase_end = sent_words + ITEM_TARGET / N_PHASES;
      while (sent_words < phase_end) begin
        if ($urandom_range(99) < 85) random_message();
        else random_fault();
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("PASS virtual_packet_reassembler");
    end else begin
      $display("FAIL virtual_packet_reassembler");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/vpr_pkg.sv
rtl/vpr_in_if.sv
rtl/vpr_out_if.sv
rtl/vpr_front.sv
rtl/vpr_queue.sv
rtl/vpr_back.sv
rtl/virtual_packet_reassembler.sv
dv/vpr_checker.sv
dv/testbench.sv
